@@ sv/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants for the subpixel row shifter
// Field widths, register map, job descriptor and back-end sequencer states.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int PIX_W    = 32;   // Q16.16 pixel
  localparam int SHIFT_W  = 16;   // Q8.8 trace offset
  localparam int CFG_W    = 7;    // row_width register
  localparam int FRAC_W   = 8;    // fraction bits of the shift
  localparam int IPART_W  = 9;    // floor integer part, -128 .. 128
  localparam int P_W      = 10;   // signed source position, -128 .. 191
  localparam int ACC_W    = 43;   // blend accumulator
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] ADDR_ROW_WIDTH = 2'd0;
  localparam logic [CFG_W-1:0]   ROW_WIDTH_RST  = 7'd64;

  // One completed row waiting in (or being emitted from) a store bank.
  typedef struct packed {
    logic               bank;
    logic [CFG_W-1:0]   width;
    logic [SHIFT_W-1:0] shift;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ADDR_A,
    B_ADDR_B,
    B_MUL,
    B_SUM
  } back_state_t;

endpackage

@@ sv/srs_ram.sv @@
// ----------------------------------------------------------------------------
// srs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/srs_front.sv @@
// ----------------------------------------------------------------------------
// srs_front: row loader
// Takes pixel requests, writes them into the current bank and queues a job
// when the row is complete.
// ----------------------------------------------------------------------------
module srs_front
  import srs_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int IDX_W     = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CFG_W-1:0]    row_width,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PIX_W-1:0]    pixel_in,
  input  logic [SHIFT_W-1:0]  trace_offset,
  input  logic                queue_full,
  output logic                ram_we,
  output logic [IDX_W:0]      ram_waddr,
  output logic [PIX_W-1:0]    ram_wdata,
  output logic                job_push,
  output job_t                job,
  output logic                wr_bank
);

  logic [IDX_W-1:0]   fill;
  logic [SHIFT_W-1:0] row_shift;
  logic [CFG_W-1:0]   weff;
  logic [CFG_W-1:0]   fill_inc;
  logic               first;
  logic               done;
  logic               accept;

  // width clamp: below 2 acts as 2, above MAX_WIDTH acts as MAX_WIDTH
  always_comb begin
    priority if (row_width < 7'd2) begin
      weff = 7'd2;
    end else if (row_width > CFG_W'(MAX_WIDTH)) begin
      weff = CFG_W'(MAX_WIDTH);
    end else begin
      weff = row_width;
    end
  end

  assign in_stall  = queue_full;
  assign accept    = in_valid && !in_stall;
  assign first     = (fill == '0);
  assign fill_inc  = CFG_W'(fill) + 7'd1;
  assign done      = (fill_inc >= weff);

  assign ram_we    = accept;
  assign ram_waddr = {wr_bank, fill};
  assign ram_wdata = pixel_in;

  assign job_push  = accept && done;
  assign job.bank  = wr_bank;
  assign job.width = weff;
  assign job.shift = first ? trace_offset : row_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      wr_bank <= 1'b0;
    end else if (accept) begin
      if (done) begin
        fill    <= '0;
        wr_bank <= ~wr_bank;
      end else begin
        fill <= fill_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_shift <= '0;
    end else if (accept && first) begin
      row_shift <= trace_offset;
    end
  end

endmodule

@@ sv/srs_job_fifo.sv @@
// ----------------------------------------------------------------------------
// srs_job_fifo: two-entry job queue
// One entry per store bank; an entry is released when its row is emitted.
// ----------------------------------------------------------------------------
module srs_job_fifo
  import srs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = ent[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/srs_back.sv @@
// ----------------------------------------------------------------------------
// srs_back: row emitter
// Walks a queued row, reads two source words, blends them and drives the
// output register.
// ----------------------------------------------------------------------------
module srs_back
  import srs_pkg::*;
#(
  parameter int IDX_W     = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    queue_empty,
  input  job_t                    head,
  output logic                    pop,
  output logic [IDX_W:0]          ram_raddr,
  input  logic [PIX_W-1:0]        ram_rdata,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PIX_W-1:0] pixel_out,
  output logic                    last_of_row,
  output logic                    load_out
);

  back_state_t state, state_next;

  // active job
  logic                      jbank;
  logic [CFG_W-1:0]          jw;
  logic [FRAC_W-1:0]         jfrac;
  logic signed [IPART_W-1:0] jipart;
  logic [IDX_W-1:0]          x;

  logic signed [SHIFT_W:0]   d;
  logic signed [P_W-1:0]     p;
  logic signed [P_W-1:0]     wp;
  logic [CFG_W-1:0]          wm1;
  logic [IDX_W-1:0]          idx_a;
  logic [IDX_W-1:0]          idx_b;
  logic [FRAC_W-1:0]         f_eff;
  logic                      last;

  logic                      take_job;
  logic                      cap_a;
  logic                      do_mul;

  logic signed [PIX_W-1:0]   a_reg;
  logic signed [ACC_W-2:0]   prod_a;
  logic signed [ACC_W-2:0]   prod_b;
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]          adj;
  logic [IPART_W-1:0]        wa;
  logic                      can_load;

  // shift = -offset at 17 bits; low byte is the fraction, the rest is floor
  assign d = -$signed({head.shift[SHIFT_W-1], head.shift});

  // source position for the current output and the words it needs
  assign p   = $signed(P_W'(x)) + P_W'(jipart);
  assign wp  = $signed(P_W'(jw));
  assign wm1 = jw - 7'd1;
  assign last = (CFG_W'(x) == wm1);

  always_comb begin
    idx_a = p[IDX_W-1:0];
    idx_b = p[IDX_W-1:0] + 1'b1;
    f_eff = jfrac;
    priority if (p < 0) begin
      idx_a = '0;
      idx_b = '0;
      f_eff = '0;
    end else if (p >= wp) begin
      idx_a = wm1[IDX_W-1:0];
      idx_b = wm1[IDX_W-1:0];
      f_eff = '0;
    end else if (jfrac == '0 || p == 0 || p == wp - 1) begin
      idx_b = p[IDX_W-1:0];
      f_eff = '0;
    end else begin
      f_eff = jfrac;
    end
  end

  assign can_load = !out_valid || !out_stall;
  assign wa       = 9'd256 - IPART_W'(f_eff);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!queue_empty) state_next = B_ADDR_A;
      B_ADDR_A: state_next = B_ADDR_B;
      B_ADDR_B: state_next = B_MUL;
      B_MUL:    state_next = B_SUM;
      B_SUM: begin
        if (can_load) begin
          state_next = last ? B_IDLE : B_ADDR_A;
        end
      end
      default:  state_next = B_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    take_job  = 1'b0;
    cap_a     = 1'b0;
    do_mul    = 1'b0;
    load_out  = 1'b0;
    pop       = 1'b0;
    ram_raddr = {jbank, idx_a};
    unique case (state)
      B_IDLE:   take_job = !queue_empty;
      B_ADDR_A: ram_raddr = {jbank, idx_a};
      B_ADDR_B: begin
        ram_raddr = {jbank, idx_b};
        cap_a     = 1'b1;
      end
      B_MUL:    do_mul = 1'b1;
      B_SUM: begin
        load_out = can_load;
        pop      = can_load && last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
    end else if (take_job) begin
      x <= '0;
    end else if (load_out) begin
      x <= x + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_job) begin
      jbank  <= head.bank;
      jw     <= head.width;
      jfrac  <= d[FRAC_W-1:0];
      jipart <= d[SHIFT_W:FRAC_W];
    end
    if (cap_a) begin
      a_reg <= $signed(ram_rdata);
    end
    if (do_mul) begin
      prod_a <= a_reg * $signed({1'b0, wa});
      prod_b <= $signed(ram_rdata) * $signed({2'b0, f_eff});
    end
  end

  // divide by 256 toward zero
  assign acc = ACC_W'(prod_a) + ACC_W'(prod_b);
  assign adj = acc + (acc[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pixel_out   <= $signed(adj[PIX_W+FRAC_W-1:FRAC_W]);
      last_of_row <= last;
    end
  end

endmodule

@@ sv/subpixel_row_shifter.sv @@
// ----------------------------------------------------------------------------
// subpixel_row_shifter: row resampler with subpixel shift
// Loads a row of Q16.16 pixels, then emits it shifted by the negated Q8.8
// trace offset of its first pixel, blending neighbors linearly.
//
//   channel   handshake            payload
//   apb       psel/penable/pready  paddr, pwrite, pwdata, prdata
//   in        in_valid/in_stall    pixel_in, trace_offset
//   out       out_valid/out_stall  pixel_out, last_of_row
//
// Loading takes one pixel request per cycle while in_stall is low; the row
//   store has two banks, so one row loads while the previous one is emitted.
// Emission walks ADDR_A, ADDR_B, MUL, SUM per result: the sequencer reads two
//   source words through the single store read port, multiplies, then sums,
//   waiting in SUM on a stalled output; IDLE between rows takes the next job.
// in_stall is high while both banks hold rows not yet fully emitted.
// Synchronous reset clears control only; the store needs no clearing pass.
// A result waiting in the output register does not stop loading.
// ----------------------------------------------------------------------------
module subpixel_row_shifter
  import srs_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  // pixel requests
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [PIX_W-1:0]   pixel_in,
  input  logic signed [SHIFT_W-1:0] trace_offset,
  // results
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [PIX_W-1:0]   pixel_out,
  output logic                      last_of_row
);

  // index bits of one bank; the store holds two banks
  localparam int IDX_W     = $clog2(MAX_WIDTH);
  localparam int RAM_DEPTH = 2 * (1 << IDX_W);

  logic [CFG_W-1:0] row_width;

  logic             ram_we;
  logic [IDX_W:0]   ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic [IDX_W:0]   ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  logic             job_push;
  job_t             job;
  job_t             head;
  logic             pop;
  logic             queue_full;
  logic             queue_empty;
  logic             wr_bank;
  logic             load_out;

  // register file: row_width only
  assign pready = 1'b1;
  assign prdata = PDATA_W'(row_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ROW_WIDTH) begin
      row_width <= pwdata[CFG_W-1:0];
    end
  end

  srs_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .row_width    (row_width),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_in     (pixel_in),
    .trace_offset (trace_offset),
    .queue_full   (queue_full),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .job_push     (job_push),
    .job          (job),
    .wr_bank      (wr_bank)
  );

  srs_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  srs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srs_back #(
    .IDX_W     (IDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .last_of_row (last_of_row),
    .load_out    (load_out)
  );

  // a finished row never lands in a full queue
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !queue_full)
    else $error("row job pushed into full queue");

  // the loader never writes into the bank being emitted
  a_bank_apart: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !queue_empty) |-> (head.bank != wr_bank))
    else $error("loader writes into bank under emission");

  // results come only from a queued row
  a_load_has_job: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !queue_empty)
    else $error("result produced with no row queued");

endmodule
